@@ rtl/core/tml_pkg.sv @@
package tml_pkg;

    localparam int SIDE_WIDTH = 16;
    localparam int OUT_WIDTH  = SIDE_WIDTH + 1;
    localparam int SQ_WIDTH   = 2 * OUT_WIDTH;
    localparam int RAD_WIDTH  = SQ_WIDTH + 1;
    localparam int HI_WIDTH   = OUT_WIDTH + 1;
    localparam int ITER_COUNT = OUT_WIDTH;
    localparam int CNT_WIDTH  = $clog2(ITER_COUNT + 1);

    typedef struct packed {
        logic [SIDE_WIDTH-1:0] side_a;
        logic [SIDE_WIDTH-1:0] side_b;
        logic [SIDE_WIDTH-1:0] side_c;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] median_length;
        logic                 invalid;
    } t_out_beat;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_seq_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_RAD,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

@@ rtl/core/tml_sq_unit.sv @@
module tml_sq_unit import tml_pkg::*; (
    input  logic                 i_clk,
    input  logic [OUT_WIDTH-1:0] i_op,
    output logic [SQ_WIDTH-1:0]  o_prod
);

    logic [SQ_WIDTH-1:0] r_prod;
    logic [SQ_WIDTH-1:0] n_prod;

    // one 17x17 squarer, result registered
    assign n_prod = SQ_WIDTH'(i_op) * SQ_WIDTH'(i_op);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/tml_seq.sv @@
module tml_seq import tml_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_beat i_in_beat,
    output logic     o_busy,
    output t_seq_res o_res,
    input  logic     i_res_take
);

    t_state                r_state, n_state;
    t_in_beat              r_in, n_in;
    logic [SQ_WIDTH-1:0]   r_aa, n_aa;
    logic [SQ_WIDTH-1:0]   r_bb, n_bb;
    logic [SQ_WIDTH-1:0]   r_rad, n_rad;
    logic [OUT_WIDTH-1:0]  r_lo, n_lo;
    logic [HI_WIDTH-1:0]   r_hi, n_hi;
    logic [CNT_WIDTH-1:0]  r_cnt, n_cnt;
    logic                  r_inv, n_inv;

    logic [OUT_WIDTH-1:0]  op;
    logic [SQ_WIDTH-1:0]   prod;
    logic [OUT_WIDTH-1:0]  mid;
    logic [RAD_WIDTH-1:0]  twice;

    tml_sq_unit u_sq (
        .i_clk  (i_clk),
        .i_op   (op),
        .o_prod (prod)
    );

    assign mid   = OUT_WIDTH'(HI_WIDTH'(r_lo) + ((r_hi - HI_WIDTH'(r_lo)) >> 1));
    assign twice = (RAD_WIDTH'(r_bb) + RAD_WIDTH'(prod)) << 1;

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_aa    = r_aa;
        n_bb    = r_bb;
        n_rad   = r_rad;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_cnt   = r_cnt;
        n_inv   = r_inv;
        op      = mid;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_beat;
                    n_state = ST_SQ_A;
                end
            end
            ST_SQ_A: begin
                op      = OUT_WIDTH'(r_in.side_a);
                n_state = ST_SQ_B;
            end
            ST_SQ_B: begin
                op      = OUT_WIDTH'(r_in.side_b);
                n_aa    = prod;
                n_state = ST_SQ_C;
            end
            ST_SQ_C: begin
                op      = OUT_WIDTH'(r_in.side_c);
                n_bb    = prod;
                n_state = ST_RAD;
            end
            ST_RAD: begin
                // prod holds c^2 here
                n_lo  = '0;
                n_hi  = HI_WIDTH'(1) << OUT_WIDTH;
                n_cnt = '0;
                if (twice < RAD_WIDTH'(r_aa)) begin
                    n_inv   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_inv   = 1'b0;
                    n_rad   = SQ_WIDTH'(twice - RAD_WIDTH'(r_aa));
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                op      = mid;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_rad < prod) begin
                    n_hi = HI_WIDTH'(mid);
                end else begin
                    n_lo = mid;
                end
                n_cnt = r_cnt + CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(ITER_COUNT - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_aa  <= n_aa;
        r_bb  <= n_bb;
        r_rad <= n_rad;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_cnt <= n_cnt;
        r_inv <= n_inv;
    end

    assign o_busy                   = (r_state != ST_IDLE);
    assign o_res.valid              = (r_state == ST_DONE);
    assign o_res.beat.median_length = r_inv ? '0 : r_lo;
    assign o_res.beat.invalid       = r_inv;

endmodule

@@ rtl/core/triangle_median_length.sv @@
// Channel | Direction | Handshake              | Beat
// --------+-----------+------------------------+--------------------------------------
// in      | input     | i_in_valid, o_in_stall | i_in_beat  (side_a, side_b, side_c)
// out     | output    | o_out_valid, i_out_stall | o_out_beat (median_length, invalid)
//
// Each beat is worked on in order: capture, three squares through the shared
// squarer, a radicand step, then 17 bisection steps (square of the midpoint,
// then compare), then the hand-off of the result to the output register.
// A negative radicand skips the search.
// Reset (i_rst_n low, synchronous) empties the sequencer and the output register.
// o_in_stall is high while a beat is being worked on; the next beat is taken
// once the result has moved to the output register, even while it is stalled.
module triangle_median_length import tml_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic      busy;
    t_seq_res  res;
    logic      res_take;

    logic      r_out_valid, n_out_valid;
    t_out_beat r_out_beat, n_out_beat;

    // sequencer: shared squarer plus bisection state
    tml_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_busy     (busy),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // output register takes the result when empty or being drained
    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (res_take) begin
            n_out_valid = 1'b1;
            n_out_beat  = res.beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
